// ===== src/tscb_pkg.sv =====
`timescale 1ns / 1ps
package tscb_pkg;
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0, CMD_READ = 3'd1, CMD_CLEAR = 3'd2, CMD_MOVE = 3'd3,
    CMD_SCRUP = 3'd4, CMD_SCRDN = 3'd5, CMD_INVERT = 3'd6, CMD_NOP = 3'd7
  } cmd_t;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_ERASE = 2'd2;

  typedef enum logic [1:0] {OP_NONE, OP_CELL, OP_RECT, OP_INV} op_t;

  // classified work for the back end
  typedef struct packed {
    op_t         op;
    logic        wr;       // cell op: write; rect op: fill (else copy)
    logic        reject;
    logic        backward;
    logic [6:0]  drow;
    logic [7:0]  dcol;
    logic [6:0]  srow;
    logic [7:0]  scol;
    logic [7:0]  h;
    logic [8:0]  w;
    logic        fill2;    // follow with a fill rectangle (scroll)
    logic [6:0]  frow;
    logic [7:0]  fh;
    logic [13:0] cnt;
    logic [15:0] value;
    logic [8:0]  nc;
  } job_t;

  function automatic logic [15:0] swap_colors(input logic [15:0] a);
    swap_colors = (a & 16'h88ff) | ((a & 16'h7000) >> 4) | ((a & 16'h0700) << 4);
  endfunction
endpackage

// ===== src/tscb_if.sv =====
`timescale 1ns / 1ps
interface tscb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [5:0] row;
  logic [6:0] col;
  logic [5:0] src_row;
  logic [6:0] src_col;
  logic [6:0] height;
  logic [7:0] width;
  logic [13:0] count;
  logic [15:0] value;
  modport source(output valid, cmd, row, col, src_row, src_col, height, width, count,
                 value, input ready);
  modport sink(input valid, cmd, row, col, src_row, src_col, height, width, count,
               value, output ready);
endinterface

interface tscb_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic        status;
  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

interface tscb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/tscb_front.sv =====
`timescale 1ns / 1ps
module tscb_front import tscb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tscb_cmd_if.sink   cmd_in,
  input  logic [7:0] columns,
  input  logic [6:0] rows,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);
  logic [8:0] nc;
  logic [7:0] nr;
  logic [7:0] lines;
  logic [15:0] start;
  logic [15:0] total;
  logic [14:0] run_end;
  job_t j;
  logic       have;
  logic       in_cell, d_in, s_in;

  assign nc = (columns > 8'(MAX_COLS)) ? 9'(MAX_COLS) : {1'b0, columns};
  assign nr = (rows > 7'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, rows};

  // start cell index; one multiply of a 6-bit row by a 9-bit column count, registered by the holding stage
  assign start = 16'(cmd_in.row) * 16'(nc) + 16'(cmd_in.col);
  assign total = 16'(nr) * 16'(nc);
  assign run_end = 15'(start) + 15'(cmd_in.count);
  assign lines = (15'(cmd_in.count) > 15'(nr)) ? nr : 8'(cmd_in.count);
  assign in_cell = (8'(cmd_in.row) < nr) && (9'(cmd_in.col) < nc);
  assign d_in = (8'(cmd_in.row) + 8'(cmd_in.height) <= nr) &&
                (9'(cmd_in.col) + 9'(cmd_in.width) <= nc);
  assign s_in = (8'(cmd_in.src_row) + 8'(cmd_in.height) <= nr) &&
                (9'(cmd_in.src_col) + 9'(cmd_in.width) <= nc);

  always_comb begin
    j = '0;
    j.drow = 7'(cmd_in.row);
    j.dcol = 8'(cmd_in.col);
    j.srow = 7'(cmd_in.src_row);
    j.scol = 8'(cmd_in.src_col);
    j.h = 8'(cmd_in.height);
    j.w = 9'(cmd_in.width);
    j.cnt = cmd_in.count;
    j.value = cmd_in.value;
    j.nc = nc;
    j.backward = !((cmd_in.row < cmd_in.src_row) ||
                   (cmd_in.row == cmd_in.src_row && cmd_in.col < cmd_in.src_col));
    case (cmd_t'(cmd_in.cmd))
      CMD_WRITE, CMD_READ: begin
        j.op = OP_CELL;
        j.wr = (cmd_in.cmd == CMD_WRITE);
        j.reject = !in_cell;
      end
      CMD_CLEAR: begin
        if (cmd_in.height != 0 && cmd_in.width != 0) begin
          j.reject = !d_in;
          j.op = d_in ? OP_RECT : OP_NONE;
          j.wr = 1'b1;
          j.frow = 7'(cmd_in.row);
        end
      end
      CMD_MOVE: begin
        if (cmd_in.height != 0 && cmd_in.width != 0) begin
          j.reject = !(d_in && s_in);
          j.op = (d_in && s_in) ? OP_RECT : OP_NONE;
        end
      end
      CMD_SCRUP, CMD_SCRDN: begin
        if (cmd_in.count != 0 && nr != 0 && nc != 0) begin
          j.op = OP_RECT;
          j.h = nr - lines;
          j.w = nc;
          j.dcol = '0;
          j.scol = '0;
          j.fill2 = 1'b1;
          j.fh = lines;
          if (cmd_in.cmd == CMD_SCRUP) begin
            j.srow = 7'(lines);
            j.drow = '0;
            j.backward = 1'b0;
            j.frow = 7'(nr - lines);
          end else begin
            j.srow = '0;
            j.drow = 7'(lines);
            j.backward = 1'b1;
            j.frow = '0;
          end
        end
      end
      CMD_INVERT: begin
        if (cmd_in.count != 0) begin
          if (!in_cell || 16'(run_end) > total) begin
            j.reject = 1'b1;
          end else begin
            j.op = OP_INV;
            j.dcol = '0;
            j.drow = '0;
            j.value = start;
          end
        end
      end
      default: ;
    endcase
  end

  // single-entry holding stage into the queue
  assign cmd_in.ready = !have || job_ready;
  assign job_valid = have;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else begin
      if (cmd_in.valid && cmd_in.ready) begin
        have <= 1'b1;
        job <= j;
      end else if (job_ready) begin
        have <= 1'b0;
      end
    end
  end
endmodule

// ===== src/tscb_fifo.sv =====
`timescale 1ns / 1ps
module tscb_fifo import tscb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t       slot [2];
  logic [1:0] fill;
  logic       wp, rp;

  assign in_ready = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_job = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        slot[wp] <= in_job;
        wp <= !wp;
      end
      if (out_valid && out_ready) rp <= !rp;
      fill <= fill + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

// ===== src/tscb_back.sv =====
`timescale 1ns / 1ps
module tscb_back import tscb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [15:0] erase_cell,
  output logic        busy,
  tscb_res_if.source  res
);
  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_ROWADDR, S_RD, S_WAIT, S_WR, S_DONE}
    state_t;
  state_t state;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  job_t        cur;
  job_t        job_first;
  logic [AW:0] clr;
  logic [7:0]  r;
  logic [8:0]  i;
  logic [13:0] n;
  logic [AW-1:0] sbase, dbase, ia;
  logic        filling;
  logic [15:0] rd_hold;
  logic        st_hold;

  logic [8:0] ci;
  logic [7:0] cr;
  logic [6:0] arow_s, arow_d;

  // a scroll with nothing to copy starts straight on its fill rows
  always_comb begin
    job_first = job;
    if (job.op == OP_RECT && job.h == 0 && job.fill2) job_first.h = job.fh;
  end

  // current column / row offset inside the rectangle, direction-dependent
  assign ci = cur.backward ? (cur.w - 9'd1 - i) : i;
  assign cr = cur.backward ? (cur.h - 8'd1 - r) : r;
  assign arow_s = cur.srow + 7'(cr);
  assign arow_d = (filling ? cur.frow : cur.drow) + 7'(cr);

  always_comb begin
    we = 1'b0;
    waddr = dbase + AW'(cur.dcol) + AW'(ci);
    wdata = filling ? erase_cell : rdata;
    raddr = sbase + AW'(cur.scol) + AW'(ci);
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr[AW-1:0];
        wdata = '0;
      end
      S_RD, S_WAIT: begin
        if (cur.op == OP_CELL) raddr = dbase + AW'(cur.dcol);
        if (cur.op == OP_INV) raddr = ia;
      end
      S_WR: begin
        we = 1'b1;
        if (cur.op == OP_CELL) begin
          waddr = dbase + AW'(cur.dcol);
          wdata = cur.value;
        end else if (cur.op == OP_INV) begin
          waddr = ia;
          wdata = swap_colors(rdata);
        end
      end
      default: ;
    endcase
  end

  assign job_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur <= job_first;
            r <= '0;
            i <= '0;
            n <= '0;
            filling <= (job.op == OP_RECT) && (job.wr || (job.h == 0 && job.fill2));
            ia <= AW'(job.value);
            rd_hold <= '0;
            st_hold <= job.reject;
            case (job.op)
              OP_NONE: state <= S_DONE;
              OP_CELL: state <= job.reject ? S_DONE : S_ROWADDR;
              OP_RECT: state <= (job.h == 0) ? (job.fill2 ? S_ROWADDR : S_DONE)
                                             : S_ROWADDR;
              default: state <= S_RD;
            endcase
          end
        end
        S_ROWADDR: begin
          sbase <= AW'(arow_s) * AW'(cur.nc);
          dbase <= AW'(cur.op == OP_CELL ? cur.drow : arow_d) * AW'(cur.nc);
          state <= (cur.op == OP_RECT && filling) ? S_WR : S_RD;
        end
        S_RD: state <= S_WAIT;
        S_WAIT: begin
          if (cur.op == OP_CELL && !cur.wr) begin
            rd_hold <= rdata;
            state <= S_DONE;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (cur.op == OP_CELL) begin
            state <= S_DONE;
          end else if (cur.op == OP_INV) begin
            ia <= ia + 1'b1;
            n <= n + 1'b1;
            state <= (n + 14'd1 == cur.cnt) ? S_DONE : S_RD;
          end else if (i + 9'd1 != cur.w) begin
            i <= i + 1'b1;
            state <= filling ? S_WR : S_RD;
          end else begin
            i <= '0;
            if (r + 8'd1 != cur.h) begin
              r <= r + 1'b1;
              state <= S_ROWADDR;
            end else if (cur.fill2 && !filling) begin
              filling <= 1'b1;
              r <= '0;
              cur.h <= cur.fh;
              state <= S_ROWADDR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.read_value <= rd_hold;
            res.status <= st_hold;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/text_screen_cell_blitter.sv =====
`timescale 1ns / 1ps
// Text screen blitter over a 128x64 array of 16-bit cells (character low byte,
// attribute high byte), addressed row*columns+col. One result per command.
// After reset a clearing pass zeroes every cell; commands queue
// during it but none runs until it ends. A front stage checks bounds and
// classifies commands into a two-entry queue; the back stage walks the
// cell memory (one read port, one write port). A rectangle copy reads and
// writes each cell and sets up a row address per row; a fill only writes
// each cell; invert reads and writes each cell; a scroll copies the kept
// rows and then fills the freed ones. Write configuration only when no
// command is in flight.
module text_screen_cell_blitter import tscb_pkg::*; (
  input logic       clk,
  input logic       rst,
  tscb_cmd_if.sink  cmd_in,
  tscb_res_if.source res_out,
  tscb_cfg_if.sink  cfg
);
  logic [7:0]  columns;
  logic [6:0]  rows;
  logic [15:0] erase_cell;

  logic fv, fr, qv, qr, busy;
  job_t fj, qj;

  // take configuration transactions at any time
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 8'd80;
      rows <= 7'd25;
      erase_cell <= 16'd32;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COLUMNS: columns <= cfg.data[7:0];
        REG_ROWS: rows <= cfg.data[6:0];
        REG_ERASE: erase_cell <= cfg.data;
        default: ;
      endcase
    end
  end

  tscb_front u_front (.clk, .rst, .cmd_in, .columns, .rows,
                      .job_valid(fv), .job_ready(fr), .job(fj));
  tscb_fifo u_fifo (.clk, .rst, .in_valid(fv), .in_ready(fr), .in_job(fj),
                    .out_valid(qv), .out_ready(qr), .out_job(qj));
  tscb_back u_back (.clk, .rst, .job_valid(qv), .job_ready(qr), .job(qj),
                    .erase_cell, .busy, .res(res_out));

  // a held result stays put until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.status))
    else $error("result dropped while stalled");
  // back end takes jobs only when idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    qv && qr |-> !busy)
    else $error("job taken while busy");
endmodule
